// ===== rtl/core/aabb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int MATRIX_FRAC_BITS = 12;
    localparam int ENTRY_WIDTH      = 16;
    localparam int COL_WIDTH        = 3 * ENTRY_WIDTH;
    localparam int TR_WIDTH         = 32;
    localparam int CFG_DATA_WIDTH   = COL_WIDTH;
    localparam int CFG_INDEX_WIDTH  = 3;

    // Box word: min x,y,z then max x,y,z, padded to whole bytes.
    localparam int BOX_WIDTH   = 6 * COORD_WIDTH;
    localparam int TDATA_WIDTH = ((BOX_WIDTH + 7) / 8) * 8;

    // Exact widths of the products and of the three-term row sums.
    localparam int PROD_WIDTH = COORD_WIDTH + ENTRY_WIDTH + 1;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int ACC_WIDTH  = SUM_WIDTH + 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MATRIX_COL0 = 3'd0,
        CFG_MATRIX_COL1 = 3'd1,
        CFG_MATRIX_COL2 = 3'd2,
        CFG_TRANSLATE_X = 3'd3,
        CFG_TRANSLATE_Y = 3'd4,
        CFG_TRANSLATE_Z = 3'd5
    } cfg_index_t;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef coord_t [2:0]           vec_t;
    typedef logic [ACC_WIDTH-1:0]   acc_t;
    typedef acc_t [2:0]             acc_vec_t;

    // Matrix entries are indexed [row][column]; am holds their magnitudes.
    typedef struct packed {
        logic [2:0][2:0][ENTRY_WIDTH-1:0] m;
        logic [2:0][2:0][ENTRY_WIDTH:0]   am;
        logic [2:0][TR_WIDTH-1:0]         tr;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/aabb_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [aabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [aabb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output aabb_pkg::cfg_t                            cfg
);
    import aabb_pkg::*;

    logic [2:0][COL_WIDTH-1:0] col_reg;
    logic [2:0][TR_WIDTH-1:0]  tr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Identity matrix and zero translation.
            for (int k = 0; k < 3; k++)
            begin
                col_reg[k] <= COL_WIDTH'(1) << (MATRIX_FRAC_BITS + ENTRY_WIDTH * k);
                tr_reg[k]  <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MATRIX_COL0: col_reg[0] <= cfg_data[COL_WIDTH-1:0];
                CFG_MATRIX_COL1: col_reg[1] <= cfg_data[COL_WIDTH-1:0];
                CFG_MATRIX_COL2: col_reg[2] <= cfg_data[COL_WIDTH-1:0];
                CFG_TRANSLATE_X: tr_reg[0]  <= cfg_data[TR_WIDTH-1:0];
                CFG_TRANSLATE_Y: tr_reg[1]  <= cfg_data[TR_WIDTH-1:0];
                CFG_TRANSLATE_Z: tr_reg[2]  <= cfg_data[TR_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The magnitude is one bit wider so that the most negative entry stays exact.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cfg.m[r][c] = col_reg[c][ENTRY_WIDTH*r +: ENTRY_WIDTH];
                if (cfg.m[r][c][ENTRY_WIDTH-1])
                    cfg.am[r][c] = (ENTRY_WIDTH+1)'(0) - {1'b1, cfg.m[r][c]};
                else
                    cfg.am[r][c] = {1'b0, cfg.m[r][c]};
            end
        end
        cfg.tr = tr_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/aabb_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_prep (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [aabb_pkg::BOX_WIDTH-1:0] in_box,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output aabb_pkg::vec_t                      center,
    output aabb_pkg::vec_t                      extent
);
    import aabb_pkg::*;

    logic valid_reg;
    vec_t center_reg;
    vec_t extent_reg;
    vec_t center_next;
    vec_t extent_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign center    = center_reg;
    assign extent    = extent_reg;

    // Halving keeps the upper bits of the exact sum, which rounds toward minus infinity.
    always_comb
    begin
        logic [COORD_WIDTH-1:0] lo;
        logic [COORD_WIDTH-1:0] hi;
        logic [COORD_WIDTH:0]   sum;
        logic [COORD_WIDTH:0]   diff;
        for (int k = 0; k < 3; k++)
        begin
            lo   = in_box[k*COORD_WIDTH +: COORD_WIDTH];
            hi   = in_box[(k+3)*COORD_WIDTH +: COORD_WIDTH];
            sum  = {lo[COORD_WIDTH-1], lo} + {hi[COORD_WIDTH-1], hi};
            diff = {hi[COORD_WIDTH-1], hi} - {lo[COORD_WIDTH-1], lo};
            center_next[k] = sum[COORD_WIDTH:1];
            extent_next[k] = diff[COORD_WIDTH:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            center_reg <= center_next;
            extent_reg <= extent_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aabb_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_dot (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire aabb_pkg::cfg_t cfg,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire aabb_pkg::vec_t center,
    input  wire aabb_pkg::vec_t extent,
    output logic          out_valid,
    input  wire logic     out_ready,
    output aabb_pkg::acc_vec_t new_center,
    output aabb_pkg::acc_vec_t new_extent
);
    import aabb_pkg::*;

    // Stage A: nine products for the center and nine for the extent.
    logic                         a_valid_reg;
    logic                         a_ready;
    logic signed [PROD_WIDTH-1:0] pc_reg [3][3];
    logic signed [PROD_WIDTH-1:0] pe_reg [3][3];
    logic signed [PROD_WIDTH-1:0] pc_next [3][3];
    logic signed [PROD_WIDTH-1:0] pe_next [3][3];

    // Stage B: row sums scaled back to coordinate format, plus translation.
    logic     b_valid_reg;
    logic     b_ready;
    acc_vec_t nc_reg;
    acc_vec_t ne_reg;
    acc_vec_t nc_next;
    acc_vec_t ne_next;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign new_center = nc_reg;
    assign new_extent = ne_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pc_next[r][k] = PROD_WIDTH'($signed(center[k])) *
                                PROD_WIDTH'($signed(cfg.m[r][k]));
                pe_next[r][k] = PROD_WIDTH'($signed(extent[k])) *
                                PROD_WIDTH'($signed(cfg.am[r][k]));
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_WIDTH-1:0] sc;
        logic signed [SUM_WIDTH-1:0] se;
        for (int r = 0; r < 3; r++)
        begin
            sc = SUM_WIDTH'(pc_reg[r][0]) + SUM_WIDTH'(pc_reg[r][1]) +
                 SUM_WIDTH'(pc_reg[r][2]);
            se = SUM_WIDTH'(pe_reg[r][0]) + SUM_WIDTH'(pe_reg[r][1]) +
                 SUM_WIDTH'(pe_reg[r][2]);
            nc_next[r] = ACC_WIDTH'(sc >>> MATRIX_FRAC_BITS) +
                         ACC_WIDTH'($signed(cfg.tr[r]));
            ne_next[r] = ACC_WIDTH'(se >>> MATRIX_FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            pc_reg <= pc_next;
            pe_reg <= pe_next;
        end
        if (b_ready && a_valid_reg)
        begin
            nc_reg <= nc_next;
            ne_reg <= ne_next;
        end
    end

    // A stalled word in stage B must stay put until it is taken.
    a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !out_ready |=> b_valid_reg && $stable(nc_reg) && $stable(ne_reg))
        else $error("stage B word changed while stalled");

    // A word in stage A is never dropped while stage B is blocked.
    a_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_ready |=> a_valid_reg)
        else $error("stage A word lost while stalled");

    // Back pressure reaches the input only when both stages are full.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> a_valid_reg && b_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== rtl/core/aabb_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aabb_out (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire aabb_pkg::acc_vec_t              new_center,
    input  wire aabb_pkg::acc_vec_t              new_extent,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [aabb_pkg::BOX_WIDTH-1:0]       out_box
);
    import aabb_pkg::*;

    localparam acc_t SAT_MAX = ACC_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam acc_t SAT_MIN = ~SAT_MAX;

    logic                 valid_reg;
    logic [BOX_WIDTH-1:0] box_reg;
    logic [BOX_WIDTH-1:0] box_next;

    function automatic coord_t saturate(input acc_t v);
        coord_t res;
        if ($signed(v) > $signed(SAT_MAX))
            res = SAT_MAX[COORD_WIDTH-1:0];
        else if ($signed(v) < $signed(SAT_MIN))
            res = SAT_MIN[COORD_WIDTH-1:0];
        else
            res = v[COORD_WIDTH-1:0];
        return res;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_box   = box_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            box_next[k*COORD_WIDTH +: COORD_WIDTH] =
                saturate(new_center[k] - new_extent[k]);
            box_next[(k+3)*COORD_WIDTH +: COORD_WIDTH] =
                saturate(new_center[k] + new_extent[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            box_reg <= box_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/aabb_affine_transform_unit.sv =====
// Affine transform of an axis-aligned box by the center/extent method.
// The slave stream takes one box per word as min and max corners in signed
// Q16.16; the master stream returns the bounding box after the transform,
// each coordinate saturated to 32 bits. The matrix columns (Q4.12 entries)
// and translation are written over the cfg channel, which is always ready;
// writes are meant to happen only while no box is in flight.
// The datapath has four register stages: center and extent, the eighteen
// products (32x16 for the center, 32x17 for the extent), the row sums with
// translation, and the final add, subtract and saturation. A box passes
// through these stages in that order, and one box is accepted in every
// cycle while the receiver keeps up. When the receiver stalls, words stay
// in their stages and the pipeline keeps filling its bubbles; s_axis_tready
// drops only once all four stages hold a word. Reset clears the stage valid
// bits and loads the identity matrix with zero translation.
`timescale 1ns / 1ps
`default_nettype none

module aabb_affine_transform_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z
    input  wire logic [aabb_pkg::TDATA_WIDTH-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [aabb_pkg::TDATA_WIDTH-1:0]          m_axis_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [aabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [aabb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import aabb_pkg::*;

    cfg_t                 cfg;
    logic                 prep_valid;
    logic                 dot_ready;
    vec_t                 center;
    vec_t                 extent;
    logic                 dot_valid;
    logic                 out_ready;
    acc_vec_t             new_center;
    acc_vec_t             new_extent;
    logic [BOX_WIDTH-1:0] out_box;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = TDATA_WIDTH'(out_box);

    aabb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aabb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_box    (s_axis_tdata[BOX_WIDTH-1:0]),
        .out_valid (prep_valid),
        .out_ready (dot_ready),
        .center    (center),
        .extent    (extent)
    );

    aabb_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (prep_valid),
        .in_ready   (dot_ready),
        .center     (center),
        .extent     (extent),
        .out_valid  (dot_valid),
        .out_ready  (out_ready),
        .new_center (new_center),
        .new_extent (new_extent)
    );

    aabb_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dot_valid),
        .in_ready   (out_ready),
        .new_center (new_center),
        .new_extent (new_extent),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_box    (out_box)
    );

endmodule

`default_nettype wire
